// File: rtl/core/slpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slpq_pkg
// Shared types and constants for the start-line pattern qualifier.
// ----------------------------------------------------------------------------
package slpq_pkg;

   localparam int CntWidth  = 8;
   localparam int PassWidth = 4;
   localparam int CsrWidth  = 8;
   localparam int CsrIdxW   = 2;

   // CSR indexes
   typedef enum logic [CsrIdxW-1:0] {
      CSR_SIGHTINGS_NEEDED = 2'd0,
      CSR_MISS_LIMIT       = 2'd1,
      CSR_HOLD_TICKS       = 2'd2,
      CSR_PASSES_TO_STOP   = 2'd3
   } csr_idx_type;

   // CSR reset values
   localparam logic [CntWidth-1:0]  SightingsNeededRst = 8'd6;
   localparam logic [CntWidth-1:0]  MissLimitRst       = 8'd3;
   localparam logic [CntWidth-1:0]  HoldTicksRst       = 8'd100;
   localparam logic [PassWidth-1:0] PassesToStopRst    = 4'd3;

   typedef struct packed {
      logic                 running;
      logic                 feature_seen;
      logic                 line_confirmed;
      logic [PassWidth-1:0] passes_done;
   } result_type;

endpackage

// File: rtl/core/start_line_pattern_qualifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// start_line_pattern_qualifier
// Qualifies a start-line feature from 8-bit sensor beats and counts passes.
// ----------------------------------------------------------------------------
// Each accepted req beat's result is registered in the result or skid entry.
// Throughput: 1 beat per cycle while req_stall is low; state update is a
//   single pass of 8-bit counter and compare logic into the result register.
// A two-entry output (result register plus skid) lets req keep flowing while
//   a result waits; req_stall rises only when both entries are full.
// Reset: synchronous, active high; clears all counters, the stop latch and
//   both output entries, and loads the CSR defaults.
// ----------------------------------------------------------------------------
module start_line_pattern_qualifier
   import slpq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // input channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_sensor_pattern,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_running,
   output logic                  rsp_feature_seen,
   output logic                  rsp_line_confirmed,
   output logic [PassWidth-1:0]  rsp_passes_done,
   // config port
   input  logic                  csr_wr_en,
   input  logic [CsrIdxW-1:0]    csr_index,
   input  logic [CsrWidth-1:0]   csr_data
);

   // ---------------------------------------------------------------- CSRs
   logic [CntWidth-1:0]  sightings_needed_ff;
   logic [CntWidth-1:0]  miss_limit_ff;
   logic [CntWidth-1:0]  hold_ticks_ff;
   logic [PassWidth-1:0] passes_to_stop_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sightings_needed_ff <= SightingsNeededRst;
         miss_limit_ff       <= MissLimitRst;
         hold_ticks_ff       <= HoldTicksRst;
         passes_to_stop_ff   <= PassesToStopRst;
      end else if (csr_wr_en) begin
         unique case (csr_idx_type'(csr_index))
            CSR_SIGHTINGS_NEEDED: sightings_needed_ff <= csr_data;
            CSR_MISS_LIMIT:       miss_limit_ff       <= csr_data;
            CSR_HOLD_TICKS:       hold_ticks_ff       <= csr_data;
            CSR_PASSES_TO_STOP:   passes_to_stop_ff   <= csr_data[PassWidth-1:0];
            default:              ;
         endcase
      end
   end

   // ---------------------------------------------------------------- handshake
   logic rsp_valid_ff, rsp_valid_in;
   logic skid_valid_ff, skid_valid_in;
   logic in_fire, out_fire;

   assign req_stall = skid_valid_ff;
   assign in_fire   = req_valid & ~req_stall;
   assign out_fire  = rsp_valid_ff & ~rsp_stall;

   // ---------------------------------------------------------------- gap test
   // Fill trailing zeros with ones; a gap remains iff the result is not a
   // solid run of ones from bit 0. An all-clear pattern fills to all ones.
   logic [8:0] fill;
   logic       seen;

   always_comb begin
      fill = {1'b0, req_sensor_pattern | (req_sensor_pattern - 8'd1)};
      seen = (fill & (fill + 9'd1)) != 9'd0;
   end

   // ---------------------------------------------------------------- state
   logic [CntWidth-1:0]  sighting_count_ff, sighting_count_in;
   logic [CntWidth-1:0]  miss_count_ff, miss_count_in;
   logic                 confirmed_ff, confirmed_in;
   logic [CntWidth-1:0]  hold_count_ff, hold_count_in;
   logic [PassWidth-1:0] pass_count_ff, pass_count_in;
   logic                 stop_latched_ff, stop_latched_in;

   always_comb begin
      logic [CntWidth-1:0]  sight_inc;
      logic [CntWidth-1:0]  miss_inc;
      logic [PassWidth-1:0] pass_inc;
      logic [CntWidth-1:0]  hold_mid;

      sight_inc = sighting_count_ff + 8'd1;
      miss_inc  = miss_count_ff + 8'd1;
      pass_inc  = pass_count_ff + 4'd1;

      sighting_count_in = sighting_count_ff;
      miss_count_in     = miss_count_ff;
      confirmed_in      = confirmed_ff;
      hold_mid          = hold_count_ff;
      pass_count_in     = pass_count_ff;
      stop_latched_in   = stop_latched_ff;

      if (seen) begin
         miss_count_in = '0;
         if (confirmed_ff) begin
            hold_mid = hold_count_ff + 8'd1;
         end else if (sight_inc >= sightings_needed_ff) begin
            confirmed_in      = 1'b1;
            hold_mid          = 8'd1;
            sighting_count_in = '0;
         end else begin
            sighting_count_in = sight_inc;
         end
      end else begin
         sighting_count_in = '0;
         if (miss_inc == miss_limit_ff) begin
            confirmed_in  = 1'b0;
            miss_count_in = '0;
            hold_mid      = '0;
         end else begin
            miss_count_in = miss_inc;
         end
      end

      // passage complete: restart hold, advance pass count, maybe stop
      hold_count_in = hold_mid;
      if (hold_mid >= hold_ticks_ff) begin
         hold_count_in = '0;
         if (pass_inc == passes_to_stop_ff) begin
            pass_count_in   = '0;
            stop_latched_in = 1'b1;
         end else begin
            pass_count_in = pass_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sighting_count_ff <= '0;
         miss_count_ff     <= '0;
         confirmed_ff      <= 1'b0;
         hold_count_ff     <= '0;
         pass_count_ff     <= '0;
         stop_latched_ff   <= 1'b0;
      end else if (in_fire) begin
         sighting_count_ff <= sighting_count_in;
         miss_count_ff     <= miss_count_in;
         confirmed_ff      <= confirmed_in;
         hold_count_ff     <= hold_count_in;
         pass_count_ff     <= pass_count_in;
         stop_latched_ff   <= stop_latched_in;
      end
   end

   // ---------------------------------------------------------------- output
   result_type result_in;
   result_type rsp_ff, rsp_in;
   result_type skid_ff;
   logic       load_main, load_skid;

   always_comb begin
      result_in.running        = ~stop_latched_in;
      result_in.feature_seen   = seen;
      result_in.line_confirmed = confirmed_in;
      result_in.passes_done    = pass_count_in;
   end

   // New beat goes to the result register when it is free or draining this
   // cycle; otherwise it parks in the skid entry.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      rsp_in        = rsp_ff;
      load_main     = 1'b0;
      load_skid     = 1'b0;
      if (skid_valid_ff) begin
         if (out_fire) begin
            rsp_in        = skid_ff;
            load_main     = 1'b1;
            skid_valid_in = 1'b0;
         end
      end else if (in_fire) begin
         if (!rsp_valid_ff || out_fire) begin
            rsp_in       = result_in;
            load_main    = 1'b1;
            rsp_valid_in = 1'b1;
         end else begin
            load_skid     = 1'b1;
            skid_valid_in = 1'b1;
         end
      end else if (out_fire) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_main) begin
         rsp_ff <= rsp_in;
      end
      if (load_skid) begin
         skid_ff <= result_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_running        = rsp_ff.running;
   assign rsp_feature_seen   = rsp_ff.feature_seen;
   assign rsp_line_confirmed = rsp_ff.line_confirmed;
   assign rsp_passes_done    = rsp_ff.passes_done;

   // ---------------------------------------------------------------- checks
   a_skid_needs_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry full while result register empty");

   a_stop_sticks: assert property (@(posedge clock) disable iff (reset)
      stop_latched_ff |=> stop_latched_ff)
      else $error("stop latch cleared without reset");

   a_confirm_clears_sightings: assert property (@(posedge clock) disable iff (reset)
      confirmed_ff |-> (sighting_count_ff == '0))
      else $error("sighting count nonzero while confirmed");

   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (in_fire && !rsp_valid_ff) |=> (rsp_valid_ff && !skid_valid_ff))
      else $error("beat into empty output did not land in result register");

   a_stall_held: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && rsp_stall) |=> skid_valid_ff)
      else $error("skid entry dropped while output stalled");

endmodule
